>>> rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, reset values and register indexes of the clamped PID
// controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // fixed widths of gains, windup bound, integral sum and register index
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned WINDUP_W  = 24;
  localparam int unsigned SUM_W     = WINDUP_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WINDUP_W-1:0] WINDUP_RST = 24'd65534;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_GAIN_P = 3'd1,
    CFG_GAIN_I = 3'd2,
    CFG_GAIN_D = 3'd3,
    CFG_DMAX   = 3'd4,
    CFG_DMIN   = 3'd5,
    CFG_WINDUP = 3'd6
  } cfg_idx_e;

endpackage

>>> rtl/core/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Fixed-point PID controller with integral anti-windup and drive clamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one signed measurement per
//   word; output channel (out_valid_o/out_ready_i) carries one clamped drive
//   per word, in order. Gains are signed Q8.8 by default. Configuration is
//   a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i); unknown indexes
//   are ignored. Write it only while no word is in flight; it is not checked.
// Timing:
//   Five register stages: input, error/integral, products, sum, output.
//   Throughput is one word per cycle while the output is not stalled; each
//   stage holds one word and the integral/history registers update as a
//   word enters the error stage.
// Stall:
//   Each stage is free when empty or when the next one moves, so bubbles
//   collapse and the input keeps accepting until all five stages are full.
// Reset:
//   Clears the pipeline and the error history, loads the default register
//   values (drive limits at full scale, windup limit 65534).
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [((DATA_WIDTH > pidc_pkg::WINDUP_W) ?
                 DATA_WIDTH : pidc_pkg::WINDUP_W)-1:0] cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]          measured_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [DATA_WIDTH-1:0]          drive_out_o
);
  import pidc_pkg::*;

  localparam int unsigned EW    = DATA_WIDTH + 1;
  localparam int unsigned D2W   = DATA_WIDTH + 3;
  localparam int unsigned PW    = GAIN_W + EW;
  localparam int unsigned IW    = GAIN_W + SUM_W;
  localparam int unsigned DW    = GAIN_W + D2W;
  localparam int unsigned ACC_W = ((SUM_W > D2W) ? SUM_W : D2W) + GAIN_W + 2;
  localparam int unsigned DRV_W = ACC_W - GAIN_FRAC_BITS;

  // configuration registers
  logic signed [DATA_WIDTH-1:0] target_q, dmax_q, dmin_q;
  logic signed [GAIN_W-1:0]     gain_p_q, gain_i_q, gain_d_q;
  logic        [WINDUP_W-1:0]   windup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      dmax_q   <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      dmin_q   <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      windup_q <= WINDUP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TARGET: target_q <= cfg_wdata_i[DATA_WIDTH-1:0];
        CFG_GAIN_P: gain_p_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_I: gain_i_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_D: gain_d_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DMAX:   dmax_q   <= cfg_wdata_i[DATA_WIDTH-1:0];
        CFG_DMIN:   dmin_q   <= cfg_wdata_i[DATA_WIDTH-1:0];
        CFG_WINDUP: windup_q <= cfg_wdata_i[WINDUP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage ready
  logic v_a_q, v_b_q, v_c_q, v_d_q, v_o_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  assign rdy_o      = !v_o_q || out_ready_i;
  assign rdy_d      = !v_d_q || rdy_o;
  assign rdy_c      = !v_c_q || rdy_d;
  assign rdy_b      = !v_b_q || rdy_c;
  assign rdy_a      = !v_a_q || rdy_b;
  assign in_ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= in_valid_i;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_o) v_o_q <= v_d_q;
    end
  end

  // input register
  logic signed [DATA_WIDTH-1:0] meas_a_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_a) begin
      meas_a_q <= measured_value_i;
    end
  end

  // error, integral and second difference
  logic signed [EW-1:0]    err_b;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [D2W-1:0]   d2_b;

  pidc_err_stage #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (v_a_q && rdy_b),
    .meas_i   (meas_a_q),
    .target_i (target_q),
    .limit_i  (windup_q),
    .err_o    (err_b),
    .sum_o    (sum_b),
    .d2_o     (d2_b)
  );

  // gain products
  logic signed [PW-1:0] p_q;
  logic signed [IW-1:0] i_q;
  logic signed [DW-1:0] d_q;

  always_ff @(posedge clk_i) begin
    if (v_b_q && rdy_c) begin
      p_q <= PW'(gain_p_q) * PW'(err_b);
      i_q <= IW'(gain_i_q) * IW'(sum_b);
      d_q <= DW'(gain_d_q) * DW'(d2_b);
    end
  end

  // sum of terms
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (v_c_q && rdy_d) begin
      acc_q <= ACC_W'(p_q) + ACC_W'(i_q) + ACC_W'(d_q);
    end
  end

  // floor shift and clamps, max first then min
  logic signed [DRV_W-1:0]      drive, dmax_ext, dmin_ext, drive_clamped;
  logic signed [DATA_WIDTH-1:0] out_q;

  always_comb begin
    drive    = DRV_W'(acc_q >>> GAIN_FRAC_BITS);
    dmax_ext = DRV_W'(dmax_q);
    dmin_ext = DRV_W'(dmin_q);
    drive_clamped = drive;
    if (drive_clamped > dmax_ext) begin
      drive_clamped = dmax_ext;
    end
    if (drive_clamped < dmin_ext) begin
      drive_clamped = dmin_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_d_q && rdy_o) begin
      out_q <= drive_clamped[DATA_WIDTH-1:0];
    end
  end

  assign out_valid_o = v_o_q;
  assign drive_out_o = out_q;

endmodule

>>> rtl/core/pidc_err_stage.sv
// ----------------------------------------------------------------------------
// pidc_err_stage
// Error, clamped integral and second difference of the error. Holds the
// controller history, which moves on only when a word enters this stage.
// ----------------------------------------------------------------------------
module pidc_err_stage #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   adv_i,
  input  logic signed [DATA_WIDTH-1:0]           meas_i,
  input  logic signed [DATA_WIDTH-1:0]           target_i,
  input  logic        [pidc_pkg::WINDUP_W-1:0]   limit_i,
  output logic signed [DATA_WIDTH:0]             err_o,
  output logic signed [pidc_pkg::SUM_W-1:0]      sum_o,
  output logic signed [DATA_WIDTH+2:0]           d2_o
);
  import pidc_pkg::*;

  localparam int unsigned EW    = DATA_WIDTH + 1;
  localparam int unsigned D2W   = DATA_WIDTH + 3;
  localparam int unsigned RAW_W = ((SUM_W > EW) ? SUM_W : EW) + 1;

  logic signed [SUM_W-1:0] error_sum_q, error_sum_d;
  logic signed [EW-1:0]    error_prev_q, error_prev2_q, err_d;
  logic signed [D2W-1:0]   d2_q, d2_d;
  logic signed [RAW_W-1:0] sum_raw, lim_pos, lim_neg;

  // error, integral with clamp, second difference
  always_comb begin
    err_d   = EW'(target_i) - EW'(meas_i);
    sum_raw = RAW_W'(error_sum_q) + RAW_W'(err_d);
    lim_pos = $signed({{(RAW_W-WINDUP_W){1'b0}}, limit_i});
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      error_sum_d = SUM_W'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      error_sum_d = SUM_W'(lim_neg);
    end else begin
      error_sum_d = SUM_W'(sum_raw);
    end
    d2_d = D2W'(err_d) - (D2W'(error_prev_q) <<< 1) + D2W'(error_prev2_q);
  end

  // history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q   <= '0;
      error_prev_q  <= '0;
      error_prev2_q <= '0;
    end else if (adv_i) begin
      error_sum_q   <= error_sum_d;
      error_prev_q  <= err_d;
      error_prev2_q <= error_prev_q;
    end
  end

  // second difference travels with the word
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d2_q <= d2_d;
    end
  end

  // the newest error and integral stay put while the word waits here
  assign err_o = error_prev_q;
  assign sum_o = error_sum_q;
  assign d2_o  = d2_q;

endmodule

>>> rtl/core/pidc_checker.sv
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks of the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidc_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] drive_out_o
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(drive_out_o))
    else $error("result word changed while stalled");

  // input backs up only behind a stalled output
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("pipeline not empty after reset");

endmodule

bind pid_controller_clamped pidc_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .drive_out_o (drive_out_o)
);
